@@ rtl/teq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and codes for the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

   localparam logic [2:0] CMD_SCHED_AT  = 3'd0;
   localparam logic [2:0] CMD_SCHED_IN  = 3'd1;
   localparam logic [2:0] CMD_CANCEL    = 3'd2;
   localparam logic [2:0] CMD_CLEAR     = 3'd3;
   localparam logic [2:0] CMD_RUN       = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_PAST    = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_NOT_DUE = 3'd4;
   localparam logic [2:0] ST_ID_OVF  = 3'd5;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] target_time;
      logic [31:0] delay;
      logic [15:0] event_id;
      logic [15:0] callback_tag;
      logic [31:0] elapsed;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        fired;
      logic [31:0] result_time;
      logic [15:0] result_id;
      logic [15:0] result_tag;
      logic [31:0] now;
      logic [31:0] wait_needed;
      logic [4:0]  pending;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN1, S_ACT, S_SCAN2, S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request
      logic scan_clr;   // reset scan accumulators
      logic scan_step;  // visit one entry
      logic act;        // apply command
      logic fin;        // build response
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;
   } sts_type;

endpackage
`default_nettype wire

@@ rtl/teq_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// teq_datapath
// Event table, current time and the per-entry scan unit.
// ----------------------------------------------------------------------------
module teq_datapath
   import teq_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   input  wire req_type     req_payload,
   input  wire ctl_type     ctl,
   output sts_type          sts,
   output rsp_type          rsp_payload
);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [31:0] time_mem [TABLE_DEPTH];
   logic [15:0] seq_mem  [TABLE_DEPTH];
   logic [15:0] tag_mem  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   logic [31:0] now_ff;
   logic [CW-1:0] count_ff;
   req_type req_ff;
   logic [31:0] tgt_ff;       // insert target time
   logic [IW-1:0] idx_ff;
   logic [31:0] rd_time_ff;
   logic [15:0] rd_seq_ff, rd_tag_ff;
   logic        rd_ok_ff;     // read data belongs to a valid entry
   logic [IW-1:0] rd_idx_ff;
   // scan accumulators
   logic        best_ok_ff;
   logic [IW-1:0] best_idx_ff;
   logic [31:0] best_time_ff;
   logic [15:0] best_seq_ff, best_tag_ff;
   logic        seen_ff;
   logic [15:0] top_ff;
   logic        slot_ok_ff;
   logic [IW-1:0] slot_ff;
   logic        match_ok_ff;
   logic [IW-1:0] match_ff;
   logic        rd_pend_ff;
   logic        rd_pend_ff_q; // registered read came from an active scan cycle
   rsp_type     rsp_ff;
   logic [2:0]  stat_ff;
   logic        fired_ff;
   logic [31:0] rt_ff;
   logic [15:0] rid_ff, rtag_ff;

   logic [32:0] sum_in;
   logic [31:0] tgt_in;
   assign sum_in = {1'b0, now_ff} + {1'b0, req_payload.delay};

   assign sts.scan_last = (idx_ff == IW'(TABLE_DEPTH - 1));

   // one registered memory read per cycle, index walks the table
   always_ff @(posedge clock) begin
      rd_time_ff <= time_mem[idx_ff];
      rd_seq_ff  <= seq_mem[idx_ff];
      rd_tag_ff  <= tag_mem[idx_ff];
      rd_idx_ff  <= idx_ff;
   end

   logic is_ins;
   assign is_ins = (req_ff.command == CMD_SCHED_AT) || (req_ff.command == CMD_SCHED_IN);
   logic better;
   assign better = !best_ok_ff || (rd_time_ff < best_time_ff) ||
                   ((rd_time_ff == best_time_ff) && (rd_seq_ff < best_seq_ff));

   logic [32:0] add_e;
   assign add_e = {1'b0, now_ff} + {1'b0, req_ff.elapsed};
   logic [31:0] adv;
   assign adv = (best_time_ff != now_ff) ? (add_e[32] ? 32'hFFFF_FFFF : add_e[31:0])
                                         : now_ff;
   logic ins_full, ins_past, ins_ovf;
   assign ins_past = tgt_ff < now_ff;
   assign ins_full = !slot_ok_ff || (count_ff >= CW'(TABLE_DEPTH));
   assign ins_ovf  = seen_ff && (top_ff == 16'hFFFF);

   always_comb tgt_in = sum_in[32] ? 32'hFFFF_FFFF : sum_in[31:0];

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_payload;
         tgt_ff <= (req_payload.command == CMD_SCHED_IN) ? tgt_in
                                                         : req_payload.target_time;
      end
      // act: apply command using scan results
      if (ctl.act) begin
         stat_ff  <= ST_OK;
         fired_ff <= 1'b0;
         rt_ff    <= '0;
         rid_ff   <= '0;
         rtag_ff  <= '0;
         if (is_ins) begin
            if (ins_past) begin
               stat_ff <= ST_PAST;
            end else if (ins_full) begin
               stat_ff <= ST_FULL;
            end else if (ins_ovf) begin
               stat_ff <= ST_ID_OVF;
            end else begin
               time_mem[slot_ff] <= tgt_ff;
               seq_mem[slot_ff]  <= seen_ff ? top_ff + 16'd1 : 16'd0;
               tag_mem[slot_ff]  <= req_ff.callback_tag;
               rt_ff  <= tgt_ff;
               rid_ff <= seen_ff ? top_ff + 16'd1 : 16'd0;
            end
         end else if (req_ff.command == CMD_RUN) begin
            if (!best_ok_ff) begin
               stat_ff <= ST_EMPTY;
            end else if (adv >= best_time_ff) begin
               fired_ff <= 1'b1;
               rt_ff    <= best_time_ff;
               rid_ff   <= best_seq_ff;
               rtag_ff  <= best_tag_ff;
            end else begin
               stat_ff <= ST_NOT_DUE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         now_ff     <= '0;
         count_ff   <= '0;
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
         rd_ok_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (count_ff == '0) now_ff <= csr_write_data;
         end
         rd_ok_ff <= valid_ff[idx_ff] && rd_pend_ff && !ctl.scan_clr;
         if (ctl.scan_clr) begin
            idx_ff     <= '0;
            rd_pend_ff <= 1'b1;
         end else if (ctl.scan_step) begin
            if (!sts.scan_last) idx_ff <= idx_ff + IW'(1);
            else rd_pend_ff <= 1'b0;
         end
         if (ctl.act) begin
            if (is_ins) begin
               if (!ins_past && !ins_full && !ins_ovf) begin
                  valid_ff[slot_ff] <= 1'b1;
                  count_ff <= count_ff + CW'(1);
               end
            end else if (req_ff.command == CMD_CANCEL) begin
               if (match_ok_ff) begin
                  valid_ff[match_ff] <= 1'b0;
                  if (count_ff != '0) count_ff <= count_ff - CW'(1);
               end
            end else if (req_ff.command == CMD_CLEAR) begin
               valid_ff <= '0;
               count_ff <= '0;
            end else if (req_ff.command == CMD_RUN) begin
               if (best_ok_ff) begin
                  if (adv >= best_time_ff) begin
                     now_ff <= best_time_ff;
                     valid_ff[best_idx_ff] <= 1'b0;
                     if (count_ff != '0) count_ff <= count_ff - CW'(1);
                  end else begin
                     now_ff <= adv;
                  end
               end
            end
         end
      end
   end

   // scan accumulators fed by the registered read
   always_ff @(posedge clock) begin
      if (ctl.scan_clr) begin
         best_ok_ff  <= 1'b0;
         seen_ff     <= 1'b0;
         top_ff      <= '0;
         slot_ok_ff  <= 1'b0;
         match_ok_ff <= 1'b0;
      end else if (ctl.scan_step) begin
         if (rd_ok_ff) begin
            if (better) begin
               best_ok_ff   <= 1'b1;
               best_idx_ff  <= rd_idx_ff;
               best_time_ff <= rd_time_ff;
               best_seq_ff  <= rd_seq_ff;
               best_tag_ff  <= rd_tag_ff;
            end
            if ((rd_time_ff == tgt_ff) && (!seen_ff || rd_seq_ff > top_ff)) begin
               seen_ff <= 1'b1;
               top_ff  <= rd_seq_ff;
            end
            if (!match_ok_ff && rd_time_ff == req_ff.target_time &&
                rd_seq_ff == req_ff.event_id) begin
               match_ok_ff <= 1'b1;
               match_ff    <= rd_idx_ff;
            end
         end else if (!slot_ok_ff && rd_pend_ff_q) begin
            slot_ok_ff <= 1'b1;
            slot_ff    <= rd_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rd_pend_ff_q <= 1'b0;
      else rd_pend_ff_q <= rd_pend_ff && !ctl.scan_clr;
   end

   always_ff @(posedge clock) begin
      if (ctl.fin) begin
         rsp_ff.status      <= stat_ff;
         rsp_ff.fired       <= fired_ff;
         rsp_ff.result_time <= rt_ff;
         rsp_ff.result_id   <= rid_ff;
         rsp_ff.result_tag  <= rtag_ff;
         rsp_ff.now         <= now_ff;
         rsp_ff.wait_needed <= (best_ok_ff && best_time_ff > now_ff) ?
                               best_time_ff - now_ff : 32'd0;
         rsp_ff.pending     <= 5'(count_ff);
      end
   end
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/teq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// teq_ctrl
// Sequencer: scan, apply, rescan for the earliest entry, respond.
// ----------------------------------------------------------------------------
module teq_ctrl
   import teq_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire sts_type sts,
   output ctl_type  ctl,
   output logic     busy,
   output logic     rsp_strobe
);
   state_type state_ff, state_in;
   logic tail_ff, tail_in; // one extra step drains the read register
   logic strobe_ff;
   logic accept;

   assign busy       = (state_ff != S_IDLE) || strobe_ff;
   assign rsp_strobe = strobe_ff;
   assign accept     = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         tail_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tail_ff   <= tail_in;
         strobe_ff <= ctl.fin;
      end
   end

   always_comb begin
      state_in = state_ff;
      tail_in  = tail_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctl.load = 1'b1;
               state_in = S_SCAN1;
               tail_in  = 1'b0;
            end
         end
         S_SCAN1, S_SCAN2: begin
            ctl.scan_step = 1'b1;
            if (tail_ff) begin
               tail_in  = 1'b0;
               state_in = (state_ff == S_SCAN1) ? S_ACT : S_DONE;
            end else if (sts.scan_last) begin
               tail_in = 1'b1;
            end
         end
         S_ACT: begin
            ctl.act      = 1'b1;
            state_in     = S_SCAN2;
         end
         S_DONE: begin
            ctl.fin  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // clear accumulators on entry to a scan
      if ((state_ff == S_IDLE && accept) || state_ff == S_ACT) begin
         ctl.scan_clr = 1'b1;
      end
   end

endmodule
`default_nettype wire

@@ rtl/timed_event_queue_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_event_queue_core
// Table of pending timed events with schedule, cancel and run-step commands.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Each command walks
// the table twice, one entry per cycle through a registered read (find slot,
// match and earliest; then earliest again after the update). The result is
// on rsp_payload, and rsp_strobe is high for a single cycle; the receiver
// cannot stall it. csr writes load the current time, but only while the
// table is empty.
module timed_event_queue_core
   import teq_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_payload,
   output logic             rsp_strobe,
   output rsp_type          rsp_payload,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);
   ctl_type ctl;
   sts_type sts;

   teq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts),
      .ctl(ctl), .busy(busy), .rsp_strobe(rsp_strobe)
   );

   teq_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_payload(req_payload), .ctl(ctl), .sts(sts), .rsp_payload(rsp_payload)
   );

endmodule
`default_nettype wire
